@@ rtl/bpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_pkg
// Number format, payload types, register indexes and saturating fixed point
// helpers shared by the Boris pusher pipeline.
// ----------------------------------------------------------------------------
package bpr_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 20;
  localparam int WIDE_BITS = 2 * WORD_BITS;

  // Divider: one prep stage, one stage per quotient bit, one rounding stage.
  localparam int DIV_LAT     = WORD_BITS + 2;
  // Square root: one prep stage, one stage per root bit.
  localparam int SQRT_PAIRS  = (WORD_BITS + FRAC_BITS + 1) / 2;
  localparam int SQRT_LAT    = SQRT_PAIRS + 1;
  localparam int LS_BITS     = 21;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [WORD_BITS-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam q_t Q_ONE  = q_t'(1) <<< FRAC_BITS;
  localparam q_t Q_HALF = q_t'(1) <<< (FRAC_BITS - 1);
  localparam q_t Q_TWO  = q_t'(2) <<< FRAC_BITS;

  localparam logic [WIDE_BITS-1:0] WIDE_POS_LIM = {{(WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [WIDE_BITS-1:0] WIDE_NEG_LIM = {{WORD_BITS{1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WIDE_BITS-1:0] WIDE_RND     = {{(WIDE_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LIGHT_SPEED  = 3'd0,
    CFG_CHARGE_SIGN  = 3'd1,
    CFG_BEAM_FRONT_X = 3'd2,
    CFG_DRAG_COEFF   = 3'd3,
    CFG_ACTIVE_DIMS  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    q_t pos_x;
    q_t pos_y;
    q_t pos_z;
    q_t vel_x;
    q_t vel_y;
    q_t vel_z;
    q_t field_ex;
    q_t field_ey;
    q_t field_ez;
    q_t field_bx;
    q_t field_by;
    q_t field_bz;
  } in_item_t;

  typedef struct packed {
    q_t new_vel_x;
    q_t new_vel_y;
    q_t new_vel_z;
    q_t new_pos_x;
    q_t new_pos_y;
    q_t new_pos_z;
  } out_item_t;

  function automatic q_t addq(q_t a, q_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? Q_MIN : Q_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic q_t subq(q_t a, q_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? Q_MIN : Q_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic q_t negq(q_t a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  // Exact product, round half away from zero, saturate.
  function automatic q_t mulq(q_t a, q_t b);
    logic signed [WIDE_BITS-1:0] ae;
    logic signed [WIDE_BITS-1:0] be;
    logic signed [WIDE_BITS-1:0] p;
    logic [WIDE_BITS-1:0] m;
    logic [WIDE_BITS-1:0] r;
    logic neg;
    ae  = a;
    be  = b;
    p   = ae * be;
    neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    m   = neg ? WIDE_BITS'(-p) : WIDE_BITS'(p);
    r   = (m + WIDE_RND) >> FRAC_BITS;
    if (neg) begin
      if (r > WIDE_NEG_LIM) return Q_MIN;
      return q_t'(WIDE_BITS'(0) - r);
    end
    if (r > WIDE_POS_LIM) return Q_MAX;
    return q_t'(r);
  endfunction

  function automatic q_t scale_sign(q_t v, logic signed [1:0] s);
    if (s == 2'sb00) return '0;
    return s[1] ? negq(v) : v;
  endfunction

endpackage

@@ rtl/bpr_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_stream_if
// Valid/ready request channel carrying one payload item.
// ----------------------------------------------------------------------------
interface bpr_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/boris_push_radiation_pressure.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boris_push_radiation_pressure
// Relativistic Boris pusher with x radiation-pressure drag, fully pipelined.
//
//  channel | dir | handshake          | payload
//  in_chan | in  | valid/ready        | position, four-velocity, E, B
//  out_chan| out | valid/ready        | new four-velocity, new position
//  cfg_*   | in  | cfg_we             | cfg_idx register index, cfg_data
//
// One particle per cycle while the output is not stalled and 1/c is settled;
// the item path holds 23 stages plus two square roots and four dividers.
// The whole pipeline advances together; a stalled output freezes every stage.
// 1/c runs in a free-running divider: after reset or a light_speed write the
// input holds off requests until it settles.
// Synchronous active-low reset clears valid bits and restores default configuration.
// ----------------------------------------------------------------------------
module boris_push_radiation_pressure (
  input  logic                                 clk,
  input  logic                                 rst_n,
  bpr_stream_if.sink                           in_chan,
  bpr_stream_if.source                         out_chan,
  input  logic                                 cfg_we,
  input  logic [bpr_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [bpr_pkg::WORD_BITS-1:0]        cfg_data
);
  localparam int W  = bpr_pkg::WORD_BITS;
  localparam int LS = bpr_pkg::LS_BITS;
  localparam int CW = $clog2(bpr_pkg::DIV_LAT + 1);

  typedef bpr_pkg::q_t q_t;

  typedef struct packed {
    q_t [2:0] u;
    q_t [2:0] b;
    q_t [2:0] e;
    q_t [2:0] pos;
    q_t       velx;
  } ctx_t;

  typedef struct packed {
    q_t [2:0] m;
    q_t [2:0] pos;
    logic     front;
  } ctx_p_t;

  // ---------------- configuration ----------------
  logic [LS-1:0]     light_r;
  logic signed [1:0] qsign_r;
  q_t                bfx_r;
  q_t                drag_r;
  logic [1:0]        dims_r;
  logic [CW-1:0]     settle_r;
  q_t                c_q;
  q_t                cinv;
  logic              cinv_ok;
  logic              en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r  <= LS'(471859);
      qsign_r  <= 2'sb01;
      bfx_r    <= '0;
      drag_r   <= '0;
      dims_r   <= 2'd3;
      settle_r <= CW'(bpr_pkg::DIV_LAT);
    end else begin
      if (cfg_we && cfg_idx == bpr_pkg::CFG_LIGHT_SPEED) begin
        settle_r <= CW'(bpr_pkg::DIV_LAT);
      end else if (settle_r != '0) begin
        settle_r <= settle_r - CW'(1);
      end
      if (cfg_we) begin
        case (cfg_idx)
          bpr_pkg::CFG_LIGHT_SPEED:  light_r <= cfg_data[LS-1:0];
          bpr_pkg::CFG_CHARGE_SIGN:  qsign_r <= cfg_data[1:0];
          bpr_pkg::CFG_BEAM_FRONT_X: bfx_r   <= cfg_data;
          bpr_pkg::CFG_DRAG_COEFF:   drag_r  <= cfg_data;
          bpr_pkg::CFG_ACTIVE_DIMS:  dims_r  <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  assign c_q     = {{(W-LS){1'b0}}, light_r};
  assign cinv_ok = (settle_r == '0);

  bpr_div u_cinv (.clk(clk), .en(1'b1), .num(bpr_pkg::Q_ONE), .den(c_q), .quo(cinv));

  // whole pipe moves unless the output register is held
  assign en            = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en && cinv_ok;

  // ---------------- S1..S4: half kick, |u|^2 ----------------
  logic v1_r, v2_r, v3_r, v4_r;
  q_t   s1_e_r [3];
  q_t   s1_b_r [3];
  q_t   s1_cv_r [3];
  q_t   s1_pos_r [3];
  q_t   s1_vx_r;
  q_t   s2_u_r [3];
  q_t   s2_b_r [3];
  q_t   s2_e_r [3];
  q_t   s2_pos_r [3];
  q_t   s2_vx_r;
  q_t   s3_uu_r [3];
  q_t   s3_cc_r;
  ctx_t s3_ctx_r;
  q_t   s4_sum_r;
  ctx_t s4_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_chan.valid && cinv_ok;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e_r[0]  <= bpr_pkg::scale_sign(bpr_pkg::mulq(in_chan.data.field_ex, bpr_pkg::Q_HALF),
                                        qsign_r);
      s1_e_r[1]  <= bpr_pkg::scale_sign(bpr_pkg::mulq(in_chan.data.field_ey, bpr_pkg::Q_HALF),
                                        qsign_r);
      s1_e_r[2]  <= bpr_pkg::scale_sign(bpr_pkg::mulq(in_chan.data.field_ez, bpr_pkg::Q_HALF),
                                        qsign_r);
      s1_b_r[0]  <= bpr_pkg::scale_sign(bpr_pkg::mulq(in_chan.data.field_bx, bpr_pkg::Q_HALF),
                                        qsign_r);
      s1_b_r[1]  <= bpr_pkg::scale_sign(bpr_pkg::mulq(in_chan.data.field_by, bpr_pkg::Q_HALF),
                                        qsign_r);
      s1_b_r[2]  <= bpr_pkg::scale_sign(bpr_pkg::mulq(in_chan.data.field_bz, bpr_pkg::Q_HALF),
                                        qsign_r);
      s1_cv_r[0] <= bpr_pkg::mulq(c_q, in_chan.data.vel_x);
      s1_cv_r[1] <= bpr_pkg::mulq(c_q, in_chan.data.vel_y);
      s1_cv_r[2] <= bpr_pkg::mulq(c_q, in_chan.data.vel_z);
      s1_pos_r[0] <= in_chan.data.pos_x;
      s1_pos_r[1] <= in_chan.data.pos_y;
      s1_pos_r[2] <= in_chan.data.pos_z;
      s1_vx_r     <= in_chan.data.vel_x;

      for (int i = 0; i < 3; i++) begin
        s2_u_r[i]   <= bpr_pkg::addq(s1_cv_r[i], s1_e_r[i]);
        s2_b_r[i]   <= bpr_pkg::mulq(s1_b_r[i], cinv);
        s2_e_r[i]   <= s1_e_r[i];
        s2_pos_r[i] <= s1_pos_r[i];
      end
      s2_vx_r <= s1_vx_r;

      for (int i = 0; i < 3; i++) begin
        s3_uu_r[i]      <= bpr_pkg::mulq(s2_u_r[i], s2_u_r[i]);
        s3_ctx_r.u[i]   <= s2_u_r[i];
        s3_ctx_r.b[i]   <= s2_b_r[i];
        s3_ctx_r.e[i]   <= s2_e_r[i];
        s3_ctx_r.pos[i] <= s2_pos_r[i];
      end
      s3_cc_r       <= bpr_pkg::mulq(c_q, c_q);
      s3_ctx_r.velx <= s2_vx_r;

      s4_sum_r <= bpr_pkg::addq(bpr_pkg::addq(bpr_pkg::addq(s3_cc_r, s3_uu_r[0]),
                                              s3_uu_r[1]), s3_uu_r[2]);
      s4_ctx_r <= s3_ctx_r;
    end
  end

  // gamma factor c / sqrt(c^2 + |u|^2)
  q_t   root_a;
  q_t   g;
  logic da_valid;
  ctx_t da_ctx;

  bpr_sqrt u_sqrt_a (.clk(clk), .en(en), .arg(s4_sum_r), .root(root_a));
  bpr_div  u_div_g  (.clk(clk), .en(en), .num(c_q), .den(root_a), .quo(g));
  bpr_delay #(.DW($bits(ctx_t)), .DEPTH(bpr_pkg::SQRT_LAT + bpr_pkg::DIV_LAT)) u_dly_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r), .in_data(s4_ctx_r),
    .out_valid(da_valid), .out_data(da_ctx)
  );

  // ---------------- S5..S7: scaled rotation vector ----------------
  logic v5_r, v6_r, v7_r;
  ctx_t c5_r, c6_r, c7_r;
  ctx_t c5_nxt;
  q_t   s6_bb_r [3];
  q_t   s7_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v5_r <= da_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_comb begin
    c5_nxt = da_ctx;
    for (int i = 0; i < 3; i++) begin
      c5_nxt.b[i] = bpr_pkg::mulq(da_ctx.b[i], g);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_r <= c5_nxt;
      c6_r <= c5_r;
      for (int i = 0; i < 3; i++) begin
        s6_bb_r[i] <= bpr_pkg::mulq(c5_r.b[i], c5_r.b[i]);
      end
      c7_r     <= c6_r;
      s7_sum_r <= bpr_pkg::addq(bpr_pkg::addq(bpr_pkg::addq(bpr_pkg::Q_ONE, s6_bb_r[0]),
                                              s6_bb_r[1]), s6_bb_r[2]);
    end
  end

  q_t   f;
  logic db_valid;
  ctx_t db_ctx;

  bpr_div u_div_f (.clk(clk), .en(en), .num(bpr_pkg::Q_TWO), .den(s7_sum_r), .quo(f));
  bpr_delay #(.DW($bits(ctx_t)), .DEPTH(bpr_pkg::DIV_LAT)) u_dly_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v7_r), .in_data(c7_r),
    .out_valid(db_valid), .out_data(db_ctx)
  );

  // ---------------- S8..S13: rotation and second half kick ----------------
  logic   v8_r, v9_r, v10_r, v11_r, v12_r, v13_r;
  ctx_t   c8_r, c9_r, c10_r, c11_r, c12_r;
  q_t     f8_r, f9_r;
  q_t     s8_xa_r [3];
  q_t     s8_xb_r [3];
  q_t     s9_t_r [3];
  q_t     s10_u1_r [3];
  q_t     s11_ya_r [3];
  q_t     s11_yb_r [3];
  q_t     s12_un_r [3];
  ctx_p_t p13_r;
  q_t     s13_vx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
    end else if (en) begin
      v8_r  <= db_valid;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= v12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c8_r <= db_ctx;
      f8_r <= f;
      s8_xa_r[0] <= bpr_pkg::mulq(db_ctx.u[1], db_ctx.b[2]);
      s8_xb_r[0] <= bpr_pkg::mulq(db_ctx.u[2], db_ctx.b[1]);
      s8_xa_r[1] <= bpr_pkg::mulq(db_ctx.u[2], db_ctx.b[0]);
      s8_xb_r[1] <= bpr_pkg::mulq(db_ctx.u[0], db_ctx.b[2]);
      s8_xa_r[2] <= bpr_pkg::mulq(db_ctx.u[0], db_ctx.b[1]);
      s8_xb_r[2] <= bpr_pkg::mulq(db_ctx.u[1], db_ctx.b[0]);

      c9_r <= c8_r;
      f9_r <= f8_r;
      for (int i = 0; i < 3; i++) begin
        s9_t_r[i] <= bpr_pkg::subq(bpr_pkg::addq(c8_r.u[i], s8_xa_r[i]), s8_xb_r[i]);
      end

      c10_r <= c9_r;
      for (int i = 0; i < 3; i++) begin
        s10_u1_r[i] <= bpr_pkg::mulq(s9_t_r[i], f9_r);
      end

      c11_r <= c10_r;
      s11_ya_r[0] <= bpr_pkg::mulq(s10_u1_r[1], c10_r.b[2]);
      s11_yb_r[0] <= bpr_pkg::mulq(s10_u1_r[2], c10_r.b[1]);
      s11_ya_r[1] <= bpr_pkg::mulq(s10_u1_r[2], c10_r.b[0]);
      s11_yb_r[1] <= bpr_pkg::mulq(s10_u1_r[0], c10_r.b[2]);
      s11_ya_r[2] <= bpr_pkg::mulq(s10_u1_r[0], c10_r.b[1]);
      s11_yb_r[2] <= bpr_pkg::mulq(s10_u1_r[1], c10_r.b[0]);

      c12_r <= c11_r;
      for (int i = 0; i < 3; i++) begin
        s12_un_r[i] <= bpr_pkg::addq(bpr_pkg::subq(bpr_pkg::addq(c11_r.u[i], s11_ya_r[i]),
                                                   s11_yb_r[i]), c11_r.e[i]);
      end

      for (int i = 0; i < 3; i++) begin
        p13_r.m[i] <= bpr_pkg::mulq(s12_un_r[i], cinv);
      end
      p13_r.pos   <= c12_r.pos;
      p13_r.front <= $signed(c12_r.pos[0]) <= bfx_r;
      s13_vx_r    <= c12_r.velx;
    end
  end

  // ---------------- S14..S17: radiation pressure operands ----------------
  logic   v14_r, v15_r, v16_r, v17_r;
  ctx_p_t p14_r, p15_r, p16_r, p17_r;
  q_t     s14_ax_r;
  q_t     s15_uxt_r;
  q_t     s16_uxt2_r;
  q_t     s16_cd_r;
  q_t     s17_gsq_r;
  q_t     s17_cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v14_r <= 1'b0;
      v15_r <= 1'b0;
      v16_r <= 1'b0;
      v17_r <= 1'b0;
    end else if (en) begin
      v14_r <= v13_r;
      v15_r <= v14_r;
      v16_r <= v15_r;
      v17_r <= v16_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p14_r      <= p13_r;
      s14_ax_r   <= bpr_pkg::addq(p13_r.m[0], s13_vx_r);
      p15_r      <= p14_r;
      s15_uxt_r  <= bpr_pkg::mulq(s14_ax_r, bpr_pkg::Q_HALF);
      p16_r      <= p15_r;
      s16_uxt2_r <= bpr_pkg::mulq(s15_uxt_r, s15_uxt_r);
      s16_cd_r   <= bpr_pkg::mulq(c_q, drag_r);
      p17_r      <= p16_r;
      s17_gsq_r  <= bpr_pkg::addq(bpr_pkg::Q_ONE, s16_uxt2_r);
      s17_cd_r   <= s16_cd_r;
    end
  end

  q_t     press;
  logic   dc_valid;
  ctx_p_t dc_ctx;

  bpr_div u_div_p (.clk(clk), .en(en), .num(s17_cd_r), .den(s17_gsq_r), .quo(press));
  bpr_delay #(.DW($bits(ctx_p_t)), .DEPTH(bpr_pkg::DIV_LAT)) u_dly_c (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v17_r), .in_data(p17_r),
    .out_valid(dc_valid), .out_data(dc_ctx)
  );

  // ---------------- S18..S20: new velocity, 1 + |v|^2 ----------------
  logic   v18_r, v19_r, v20_r;
  ctx_p_t p18_r, p19_r, p20_r;
  ctx_p_t p18_nxt;
  q_t     s19_nn_r [3];
  q_t     s20_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v18_r <= 1'b0;
      v19_r <= 1'b0;
      v20_r <= 1'b0;
    end else if (en) begin
      v18_r <= dc_valid;
      v19_r <= v18_r;
      v20_r <= v19_r;
    end
  end

  always_comb begin
    p18_nxt      = dc_ctx;
    p18_nxt.m[0] = bpr_pkg::addq(dc_ctx.m[0], dc_ctx.front ? press : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p18_r      <= p18_nxt;
      p19_r      <= p18_r;
      for (int i = 0; i < 3; i++) begin
        s19_nn_r[i] <= bpr_pkg::mulq(p18_r.m[i], p18_r.m[i]);
      end
      p20_r     <= p19_r;
      s20_sum_r <= bpr_pkg::addq(bpr_pkg::addq(bpr_pkg::addq(bpr_pkg::Q_ONE, s19_nn_r[0]),
                                               s19_nn_r[1]), s19_nn_r[2]);
    end
  end

  q_t     root_b;
  q_t     ginv;
  logic   dd_valid;
  ctx_p_t dd_ctx;

  bpr_sqrt u_sqrt_b (.clk(clk), .en(en), .arg(s20_sum_r), .root(root_b));
  bpr_div  u_div_gi (.clk(clk), .en(en), .num(bpr_pkg::Q_ONE), .den(root_b), .quo(ginv));
  bpr_delay #(.DW($bits(ctx_p_t)), .DEPTH(bpr_pkg::SQRT_LAT + bpr_pkg::DIV_LAT)) u_dly_d (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v20_r), .in_data(p20_r),
    .out_valid(dd_valid), .out_data(dd_ctx)
  );

  // ---------------- S21..S23: position advance, output register ----------------
  logic               v21_r, v22_r, out_valid_r;
  ctx_p_t             p21_r, p22_r;
  q_t                 s21_w_r [3];
  q_t                 s22_d_r [3];
  bpr_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v21_r       <= 1'b0;
      v22_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v21_r       <= dd_valid;
      v22_r       <= v21_r;
      out_valid_r <= v22_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p21_r <= dd_ctx;
      for (int i = 0; i < 3; i++) begin
        s21_w_r[i] <= bpr_pkg::mulq(dd_ctx.m[i], ginv);
      end
      p22_r <= p21_r;
      for (int i = 0; i < 3; i++) begin
        s22_d_r[i] <= bpr_pkg::mulq(s21_w_r[i], c_q);
      end
      out_r.new_vel_x <= p22_r.m[0];
      out_r.new_vel_y <= p22_r.m[1];
      out_r.new_vel_z <= p22_r.m[2];
      out_r.new_pos_x <= (dims_r >= 2'd1) ? bpr_pkg::addq(p22_r.pos[0], s22_d_r[0])
                                          : p22_r.pos[0];
      out_r.new_pos_y <= (dims_r >= 2'd2) ? bpr_pkg::addq(p22_r.pos[1], s22_d_r[1])
                                          : p22_r.pos[1];
      out_r.new_pos_z <= (dims_r == 2'd3) ? bpr_pkg::addq(p22_r.pos[2], s22_d_r[2])
                                          : p22_r.pos[2];
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // ---------------- checks ----------------
  a_no_req_before_cinv: assert property (@(posedge clk) disable iff (!rst_n)
    !cinv_ok |-> !in_chan.ready)
    else $error("input ready while 1/c not settled");

  a_cinv_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_idx == bpr_pkg::CFG_LIGHT_SPEED) |=> !cinv_ok)
    else $error("light speed write did not restart 1/c settle");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("request taken while output stalled");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> ($stable(v22_r) && $stable(v13_r)))
    else $error("pipeline moved during stall");
endmodule

@@ rtl/bpr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_div
// Pipelined Q-format divider: restoring, one quotient bit per stage,
// rounded half away from zero and saturated.
// ----------------------------------------------------------------------------
module bpr_div (
  input  logic          clk,
  input  logic          en,
  input  bpr_pkg::q_t   num,
  input  bpr_pkg::q_t   den,
  output bpr_pkg::q_t   quo
);
  localparam int W = bpr_pkg::WORD_BITS;
  localparam int F = bpr_pkg::FRAC_BITS;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] q;
    logic [W-1:0] low;
    logic [W-1:0] den;
    logic         zero;
    logic         ovf;
    logic         neg;
    logic         nz;
    logic         nsign;
  } dstg_t;

  dstg_t stg_r [0:W];
  dstg_t prep_nxt;
  bpr_pkg::q_t quo_r;
  bpr_pkg::q_t quo_nxt;

  always_comb begin
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [W+F-1:0] nw;
    ma = num[W-1] ? W'(-num) : W'(num);
    mb = den[W-1] ? W'(-den) : W'(den);
    nw = {ma, {F{1'b0}}};
    prep_nxt.rem   = W'(nw[W+F-1:W]);
    prep_nxt.low   = nw[W-1:0];
    prep_nxt.q     = '0;
    prep_nxt.den   = mb;
    prep_nxt.zero  = (mb == '0);
    // quotient would need more than W bits
    prep_nxt.ovf   = W'(nw[W+F-1:W]) >= mb;
    prep_nxt.neg   = num[W-1] ^ den[W-1];
    prep_nxt.nz    = (num != '0);
    prep_nxt.nsign = num[W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= prep_nxt;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_bit
    dstg_t nxt;
    always_comb begin
      logic [W:0] sh;
      logic       ge;
      nxt = stg_r[k-1];
      sh  = {stg_r[k-1].rem, stg_r[k-1].low[W-1]};
      ge  = sh >= {1'b0, stg_r[k-1].den};
      sh  = ge ? sh - {1'b0, stg_r[k-1].den} : sh;
      nxt.rem = sh[W-1:0];
      nxt.q   = {stg_r[k-1].q[W-2:0], ge};
      nxt.low = stg_r[k-1].low << 1;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= nxt;
      end
    end
  end

  always_comb begin
    logic       rnd;
    logic [W:0] q1;
    logic [W:0] lim;
    rnd = stg_r[W].rem >= (stg_r[W].den - stg_r[W].rem);
    q1  = {1'b0, stg_r[W].q} + {{W{1'b0}}, rnd};
    lim = stg_r[W].neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    if (stg_r[W].zero) begin
      quo_nxt = stg_r[W].nz ? (stg_r[W].nsign ? bpr_pkg::Q_MIN : bpr_pkg::Q_MAX) : '0;
    end else if (stg_r[W].ovf || q1 > lim) begin
      quo_nxt = stg_r[W].neg ? bpr_pkg::Q_MIN : bpr_pkg::Q_MAX;
    end else begin
      quo_nxt = stg_r[W].neg ? bpr_pkg::q_t'(-q1) : bpr_pkg::q_t'(q1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;
endmodule

@@ rtl/bpr_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_sqrt
// Pipelined Q-format square root: floor of the exact root, one root bit per
// stage; zero for arguments at or below zero.
// ----------------------------------------------------------------------------
module bpr_sqrt (
  input  logic        clk,
  input  logic        en,
  input  bpr_pkg::q_t arg,
  output bpr_pkg::q_t root
);
  localparam int W = bpr_pkg::WORD_BITS;
  localparam int F = bpr_pkg::FRAC_BITS;
  localparam int P = bpr_pkg::SQRT_PAIRS;

  typedef struct packed {
    logic [2*P-1:0] rad;
    logic [P+1:0]   rem;
    logic [P-1:0]   rt;
  } sstg_t;

  sstg_t stg_r [0:P];
  sstg_t prep_nxt;

  always_comb begin
    prep_nxt.rem = '0;
    prep_nxt.rt  = '0;
    if (!arg[W-1] && arg != '0) begin
      prep_nxt.rad = (2*P)'({arg[W-2:0], {F{1'b0}}});
    end else begin
      prep_nxt.rad = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= prep_nxt;
    end
  end

  for (genvar k = 1; k <= P; k++) begin : g_bit
    sstg_t nxt;
    always_comb begin
      logic [P+3:0] cur;
      logic [P+3:0] trial;
      logic         ge;
      cur   = {stg_r[k-1].rem, stg_r[k-1].rad[2*P-1:2*P-2]};
      trial = {2'b00, stg_r[k-1].rt, 2'b01};
      ge    = cur >= trial;
      cur   = ge ? cur - trial : cur;
      nxt.rem = cur[P+1:0];
      nxt.rt  = {stg_r[k-1].rt[P-2:0], ge};
      nxt.rad = stg_r[k-1].rad << 2;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= nxt;
      end
    end
  end

  assign root = {{(W-P){1'b0}}, stg_r[P].rt};
endmodule

@@ rtl/bpr_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpr_delay
// Context line that keeps an item's side values and valid bit in step with a
// divider or square root pipeline.
// ----------------------------------------------------------------------------
module bpr_delay #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  output logic [DW-1:0] out_data
);
  logic [DEPTH-1:0] valid_r;
  logic [DW-1:0]    data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data_r[i] <= data_r[i-1];
      end
    end
  end

  assign out_valid = valid_r[DEPTH-1];
  assign out_data  = data_r[DEPTH-1];
endmodule
